// File: hw/rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants for the quaternion to Euler angle pipeline: arctangent
// table and stage counts.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STEPS = 32;
    // normalize, fold, one stage per rotation, round
    localparam int ATAN_LAT     = CORDIC_STEPS + 5;
    localparam int ISQ_STEPS    = 31;
    localparam int NORM_BITS    = 30;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// File: hw/rtl/qte_if.sv
// ----------------------------------------------------------------------------
// qte_in_if / qte_out_if
// Valid/ready channels carrying one quaternion and one set of Euler angles.
// ----------------------------------------------------------------------------
interface qte_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] quat_w;
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

interface qte_out_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] roll_angle;
    logic signed [W-1:0] pitch_angle;
    logic signed [W-1:0] yaw_angle;
    logic                pitch_clamped;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, output pitch_clamped, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, input pitch_clamped, output ready);
endinterface

// File: hw/rtl/qte_atan2.sv
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined atan2: normalize to 30 bits, fold into the right half plane,
// one CORDIC rotation per stage, round to a binary angle.
// ----------------------------------------------------------------------------
module qte_atan2 #(
    parameter int IW = 32,
    parameter int AB = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [IW-1:0] y,
    input  logic signed [IW-1:0] x,
    output logic signed [AB-1:0] angle
);

    localparam int BLW = $clog2(IW + 1);
    localparam int EW  = IW + qte_pkg::NORM_BITS + 1;
    localparam int CW  = 34;
    localparam int NS  = qte_pkg::CORDIC_STEPS;
    localparam int SH  = 32 - AB;
    localparam logic [32:0] RND = (33'd1 << SH) >> 1;

    logic [IW-1:0] mag_x;
    logic [IW-1:0] mag_y;
    logic [BLW-1:0] bitlen;
    logic signed [EW-1:0] ext_x;
    logic signed [EW-1:0] ext_y;
    logic signed [EW-1:0] shx;
    logic signed [EW-1:0] shy;
    logic [32:0] rnd_sum;

    logic signed [IW-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [IW-1:0]        ma_reg;
    logic [BLW-1:0]       blb_reg;
    logic                 zb_reg, zc_reg;
    logic signed [CW-1:0] xc_reg, yc_reg;
    logic signed [CW-1:0] xs_reg [NS+1];
    logic signed [CW-1:0] ys_reg [NS+1];
    logic [31:0]          zs_reg [NS+1];
    logic                 zf_reg [NS+1];
    logic signed [AB-1:0] angle_reg;

    assign mag_x = x[IW-1] ? (~x + 1'b1) : x;
    assign mag_y = y[IW-1] ? (~y + 1'b1) : y;

    // bit length of the larger magnitude
    always_comb
    begin
        bitlen = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (ma_reg[i])
                bitlen = BLW'(i + 1);
        end
    end

    // scale by 2^30 then shift down by the bit length
    assign ext_x = EW'(signed'({xb_reg, {qte_pkg::NORM_BITS{1'b0}}}));
    assign ext_y = EW'(signed'({yb_reg, {qte_pkg::NORM_BITS{1'b0}}}));
    assign shx   = ext_x >>> blb_reg;
    assign shy   = ext_y >>> blb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg  <= x;
            ya_reg  <= y;
            ma_reg  <= (mag_x > mag_y) ? mag_x : mag_y;
            xb_reg  <= xa_reg;
            yb_reg  <= ya_reg;
            blb_reg <= bitlen;
            zb_reg  <= (ma_reg == '0);
            xc_reg  <= shx[CW-1:0];
            yc_reg  <= shy[CW-1:0];
            zc_reg  <= zb_reg;
            // fold the left half plane over, starting from pi
            if (xc_reg < 0)
            begin
                xs_reg[0] <= -xc_reg;
                ys_reg[0] <= -yc_reg;
                zs_reg[0] <= 32'h8000_0000;
            end
            else
            begin
                xs_reg[0] <= xc_reg;
                ys_reg[0] <= yc_reg;
                zs_reg[0] <= 32'h0;
            end
            zf_reg[0] <= zc_reg;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        logic signed [CW-1:0] xsh;
        logic signed [CW-1:0] ysh;
        assign xsh = xs_reg[i] >>> i;
        assign ysh = ys_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (ys_reg[i] > 0)
                begin
                    xs_reg[i+1] <= xs_reg[i] + ysh;
                    ys_reg[i+1] <= ys_reg[i] - xsh;
                    zs_reg[i+1] <= zs_reg[i] + qte_pkg::ATAN_TURN[i];
                end
                else
                begin
                    xs_reg[i+1] <= xs_reg[i] - ysh;
                    ys_reg[i+1] <= ys_reg[i] + xsh;
                    zs_reg[i+1] <= zs_reg[i] - qte_pkg::ATAN_TURN[i];
                end
                zf_reg[i+1] <= zf_reg[i];
            end
        end
    end

    assign rnd_sum = {1'b0, zs_reg[NS]} + RND;

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= zf_reg[NS] ? '0 : signed'(rnd_sum[SH +: AB]);
    end

    assign angle = angle_reg;

endmodule

// File: hw/rtl/quaternion_to_euler_angles_top.sv
// Pipeline from input transaction to result: 2 product/sum stages, 3 sine-square
// stages, 31 square-root stages, 37 arctangent stages, 1 output stage.
// Throughput: one transaction per cycle unless stalled; pitch path sets the depth.
// A held result freezes the whole pipeline until it is taken.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Unit quaternion to roll, pitch and yaw binary angles (Z-Y-X order).
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top #(
    parameter int COMPONENT_BITS = 16,
    parameter int ANGLE_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    qte_in_if.sink      quat,
    qte_out_if.source   euler
);

    localparam int C       = COMPONENT_BITS;
    localparam int AB      = ANGLE_BITS;
    localparam int PS      = (2 * C > 62) ? (2 * C - 62) : 0;
    localparam int PW      = 2 * C - PS;
    localparam int SW      = PW + 3;
    localparam int ONE_EXP = PW - 4;
    localparam int QK      = ONE_EXP - 30;
    localparam int QKP     = (QK > 0) ? QK : 0;
    localparam int QKN     = (QK < 0) ? -QK : 0;
    localparam int QW      = SW + QKN;
    localparam int NQ      = qte_pkg::ISQ_STEPS;
    localparam int DLY     = 3 + NQ;
    localparam int CLD     = DLY + qte_pkg::ATAN_LAT;
    localparam int DEPTH   = 2 + CLD + 1;
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< ONE_EXP;
    localparam logic signed [AB-1:0] QTR = AB'(1) <<< (AB - 2);

    logic adv;
    logic [DEPTH-1:0] vld_reg;

    // ---------------- products ----------------
    logic signed [2*C-1:0] m_wx, m_yz, m_xx, m_yy, m_wz, m_xy, m_zz, m_wy, m_zx;
    logic signed [PW-1:0]  p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [PW-1:0]  p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;

    assign m_wx = quat.quat_w * quat.quat_x;
    assign m_yz = quat.quat_y * quat.quat_z;
    assign m_xx = quat.quat_x * quat.quat_x;
    assign m_yy = quat.quat_y * quat.quat_y;
    assign m_wz = quat.quat_w * quat.quat_z;
    assign m_xy = quat.quat_x * quat.quat_y;
    assign m_zz = quat.quat_z * quat.quat_z;
    assign m_wy = quat.quat_w * quat.quat_y;
    assign m_zx = quat.quat_z * quat.quat_x;

    // ---------------- sums ----------------
    logic signed [SW-1:0] sr_next, cr_next, sy_next, cy_next, sp_next;
    logic signed [SW-1:0] sr_reg, cr_reg, sy_reg, cy_reg, sp_reg;

    assign sr_next = (SW'(p_wx_reg) + SW'(p_yz_reg)) <<< 1;
    assign cr_next = ONE - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
    assign sy_next = (SW'(p_wz_reg) + SW'(p_xy_reg)) <<< 1;
    assign cy_next = ONE - ((SW'(p_yy_reg) + SW'(p_zz_reg)) <<< 1);
    assign sp_next = (SW'(p_wy_reg) - SW'(p_zx_reg)) <<< 1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_wx_reg <= PW'(m_wx >>> PS);
            p_yz_reg <= PW'(m_yz >>> PS);
            p_xx_reg <= PW'(m_xx >>> PS);
            p_yy_reg <= PW'(m_yy >>> PS);
            p_wz_reg <= PW'(m_wz >>> PS);
            p_xy_reg <= PW'(m_xy >>> PS);
            p_zz_reg <= PW'(m_zz >>> PS);
            p_wy_reg <= PW'(m_wy >>> PS);
            p_zx_reg <= PW'(m_zx >>> PS);
            sr_reg   <= sr_next;
            cr_reg   <= cr_next;
            sy_reg   <= sy_next;
            cy_reg   <= cy_next;
            sp_reg   <= sp_next;
        end
    end

    // ---------------- pitch: cosine from sqrt(1 - s^2) ----------------
    logic signed [QW-1:0] q_ext;
    logic signed [31:0]   s30_next;
    logic [31:0]          s30_abs;
    logic signed [31:0]   s30_p1_reg, s30_p2_reg;
    logic [29:0]          sq_p1_reg;
    logic [59:0]          sq2_p2_reg;
    logic [1:0]           cl_next;
    logic [1:0]           cl_reg [CLD];

    assign q_ext    = (QW'(sp_reg) >>> QKP) <<< QKN;
    assign s30_next = q_ext[31:0];
    assign s30_abs  = s30_next[31] ? (~s30_next + 1'b1) : s30_next;
    // bit 1: saturate high, bit 0: saturate low
    assign cl_next  = {(sp_reg >= ONE), (sp_reg <= -ONE)};

    logic [61:0]        n_reg [NQ+1];
    logic [61:0]        r_reg [NQ+1];
    logic signed [31:0] s_reg [NQ+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s30_p1_reg <= s30_next;
            sq_p1_reg  <= s30_abs[29:0];
            s30_p2_reg <= s30_p1_reg;
            sq2_p2_reg <= sq_p1_reg * sq_p1_reg;
            n_reg[0]   <= (62'd1 << 60) - {2'b00, sq2_p2_reg};
            r_reg[0]   <= '0;
            s_reg[0]   <= s30_p2_reg;
            cl_reg[0]  <= cl_next;
            for (int i = 1; i < CLD; i++)
                cl_reg[i] <= cl_reg[i-1];
        end
    end

    // one result bit per stage, trial subtract of res + 4^k
    for (genvar j = 0; j < NQ; j++)
    begin : g_isq
        localparam logic [61:0] BIT = 62'd1 << (2 * (NQ - 1 - j));
        logic [61:0] trial;
        assign trial = r_reg[j] + BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (n_reg[j] >= trial)
                begin
                    n_reg[j+1] <= n_reg[j] - trial;
                    r_reg[j+1] <= (r_reg[j] >> 1) + BIT;
                end
                else
                begin
                    n_reg[j+1] <= n_reg[j];
                    r_reg[j+1] <= r_reg[j] >> 1;
                end
                s_reg[j+1] <= s_reg[j];
            end
        end
    end

    logic signed [31:0] cos_p;
    assign cos_p = signed'({1'b0, r_reg[NQ][30:0]});

    // ---------------- arctangents ----------------
    logic signed [AB-1:0] roll_a, yaw_a, pitch_a;

    qte_atan2 #(.IW(SW), .AB(AB)) u_roll (
        .clk   (clk),
        .en    (adv),
        .y     (sr_reg),
        .x     (cr_reg),
        .angle (roll_a)
    );

    qte_atan2 #(.IW(SW), .AB(AB)) u_yaw (
        .clk   (clk),
        .en    (adv),
        .y     (sy_reg),
        .x     (cy_reg),
        .angle (yaw_a)
    );

    qte_atan2 #(.IW(32), .AB(AB)) u_pitch (
        .clk   (clk),
        .en    (adv),
        .y     (s_reg[NQ]),
        .x     (cos_p),
        .angle (pitch_a)
    );

    // hold roll and yaw until the pitch path catches up
    logic signed [AB-1:0] rd_reg [DLY];
    logic signed [AB-1:0] yd_reg [DLY];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg[0] <= roll_a;
            yd_reg[0] <= yaw_a;
            for (int i = 1; i < DLY; i++)
            begin
                rd_reg[i] <= rd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
            end
        end
    end

    // ---------------- output stage ----------------
    logic signed [AB-1:0] pitch_next;
    logic signed [AB-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                 clamp_reg;

    always_comb
    begin
        if (cl_reg[CLD-1][1])
            pitch_next = QTR;
        else if (cl_reg[CLD-1][0])
            pitch_next = -QTR;
        else if (pitch_a > QTR)
            pitch_next = QTR;
        else if (pitch_a < -QTR)
            pitch_next = -QTR;
        else
            pitch_next = pitch_a;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg  <= rd_reg[DLY-1];
            yaw_reg   <= yd_reg[DLY-1];
            pitch_reg <= pitch_next;
            clamp_reg <= |cl_reg[CLD-1];
        end
    end

    // ---------------- handshake ----------------
    assign adv        = !vld_reg[DEPTH-1] || euler.ready;
    assign quat.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], quat.valid};
    end

    assign euler.valid         = vld_reg[DEPTH-1];
    assign euler.roll_angle    = roll_reg;
    assign euler.pitch_angle   = pitch_reg;
    assign euler.yaw_angle     = yaw_reg;
    assign euler.pitch_clamped = clamp_reg;

    // ---------------- assertions ----------------
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid && euler.pitch_clamped |->
            (euler.pitch_angle == QTR) || (euler.pitch_angle == -QTR))
        else $error("clamped pitch is not a quarter turn");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.pitch_angle <= QTR) && (euler.pitch_angle >= -QTR))
        else $error("pitch outside half pi");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !quat.ready |-> euler.valid && !euler.ready)
        else $error("input stalled without a held result");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks quaternion_to_euler_angles_top against a bit-exact predictor of
// roll, pitch and yaw (CORDIC arctangent, integer square root, pitch clamp).
// Random idling on both channels; results are compared in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int CB         = 16;
    localparam int AB         = 16;
    localparam int LIMIT      = 600000;
    localparam int SETTLE     = 120;
    localparam longint ONE_Q  = longint'(1) << (2 * CB - 4);
    localparam longint QUART  = longint'(1) << (AB - 2);

    typedef struct packed {
        logic signed [AB-1:0] roll;
        logic signed [AB-1:0] pitch;
        logic signed [AB-1:0] yaw;
        logic                 clamped;
    } euler_t;

    logic clk;
    logic rst_n;

    qte_in_if  #(.W(CB)) quat_ch ();
    qte_out_if #(.W(AB)) euler_ch ();

    quaternion_to_euler_angles_top #(
        .COMPONENT_BITS(CB),
        .ANGLE_BITS    (AB)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .quat (quat_ch),
        .euler(euler_ch)
    );

    euler_t angles_pending[$];
    int     n_mismatch;
    int     n_sent;
    int     n_checked;
    int     n_clamped;
    int     cycle_count;
    bit     sink_steady;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // -------- predictor --------
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] turn_atan2(longint y, longint x);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned m;
        int              n;
        logic [31:0]     z;
        longint          xs;
        longint          ys;
        ax = (x < 0) ? longint'(-x) : x;
        ay = (y < 0) ? longint'(-y) : y;
        m = (ax > ay) ? ax : ay;
        n = 0;
        z = 0;
        if (m == 0)
            return 0;
        if (m >= (64'd1 << 30))
        begin
            while ((m >> n) >= (64'd1 << 30))
                n++;
            x = x >>> n;
            y = y >>> n;
        end
        else
        begin
            while ((m << n) < (64'd1 << 29))
                n++;
            x = x <<< n;
            y = y <<< n;
        end
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + qte_pkg::ATAN_TURN[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - qte_pkg::ATAN_TURN[i];
            end
        end
        return z;
    endfunction

    function automatic logic [AB-1:0] round_angle(logic [31:0] a);
        longint unsigned r;
        r = (longint'(a) + (longint'(1) << (31 - AB))) >> (32 - AB);
        return r[AB-1:0];
    endfunction

    function automatic euler_t predict_euler(logic signed [CB-1:0] qw,
                                             logic signed [CB-1:0] qx,
                                             logic signed [CB-1:0] qy,
                                             logic signed [CB-1:0] qz);
        longint          w, x, y, z;
        longint          sr, cr, sy, cy, sp, s30, pv;
        longint unsigned sq;
        longint unsigned c;
        euler_t          e;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        sr = 2 * (w * x + y * z);
        cr = ONE_Q - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = ONE_Q - 2 * (y * y + z * z);
        sp = 2 * (w * y - z * x);
        e.clamped = 1'b0;
        if (sp >= ONE_Q)
        begin
            pv = QUART;
            e.clamped = 1'b1;
        end
        else if (sp <= -ONE_Q)
        begin
            pv = -QUART;
            e.clamped = 1'b1;
        end
        else
        begin
            s30 = sp <<< (30 - (2 * CB - 4));
            sq = (s30 < 0) ? longint'(-s30) : s30;
            c = int_sqrt((64'd1 << 60) - sq * sq);
            pv = longint'(signed'(round_angle(turn_atan2(s30, longint'(c)))));
            if (pv > QUART)
                pv = QUART;
            if (pv < -QUART)
                pv = -QUART;
        end
        e.pitch = pv[AB-1:0];
        e.roll  = round_angle(turn_atan2(sr, cr));
        e.yaw   = round_angle(turn_atan2(sy, cy));
        return e;
    endfunction

    // -------- checking --------
    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %0s: got %0d expected %0d (result %0d)",
                 what, got, want, n_checked);
        n_mismatch++;
    endtask

    always @(posedge clk)
    begin
        euler_t want;
        if (rst_n && euler_ch.valid && euler_ch.ready)
        begin
            if (angles_pending.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                want = angles_pending.pop_front();
                if (euler_ch.roll_angle !== want.roll)
                    report_mismatch("roll", euler_ch.roll_angle, want.roll);
                if (euler_ch.pitch_angle !== want.pitch)
                    report_mismatch("pitch", euler_ch.pitch_angle, want.pitch);
                if (euler_ch.yaw_angle !== want.yaw)
                    report_mismatch("yaw", euler_ch.yaw_angle, want.yaw);
                if (euler_ch.pitch_clamped !== want.clamped)
                    report_mismatch("clamp", euler_ch.pitch_clamped, want.clamped);
                if (want.clamped)
                    n_clamped++;
            end
            n_checked++;
        end
    end

    // receiver stalls in bursts
    always @(negedge clk)
    begin
        int burst;
        if (!rst_n || sink_steady)
            euler_ch.ready <= 1'b1;
        else if (burst > 0)
        begin
            burst--;
            if (burst == 0)
                euler_ch.ready <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(1, 16);
            euler_ch.ready <= 1'b0;
        end
        else
            euler_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // -------- stimulus --------
    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_quat(int qw, int qx, int qy, int qz);
        quat_ch.valid  <= 1'b1;
        quat_ch.quat_w <= qw[CB-1:0];
        quat_ch.quat_x <= qx[CB-1:0];
        quat_ch.quat_y <= qy[CB-1:0];
        quat_ch.quat_z <= qz[CB-1:0];
        do
            @(posedge clk);
        while (!quat_ch.ready);
        angles_pending.push_back(predict_euler(qw[CB-1:0], qx[CB-1:0],
                                               qy[CB-1:0], qz[CB-1:0]));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic maybe_idle(bit allow);
        int gap;
        if (allow && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 16);
            quat_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_unit(bit allow);
        real a, b, c, d, nrm;
        do
        begin
            a = real'(int'($urandom_range(0, 65535)) - 32768);
            b = real'(int'($urandom_range(0, 65535)) - 32768);
            c = real'(int'($urandom_range(0, 65535)) - 32768);
            d = real'(int'($urandom_range(0, 65535)) - 32768);
            nrm = $sqrt(a * a + b * b + c * c + d * d);
        end
        while (nrm < 1.0);
        send_quat($rtoi(16384.0 * a / nrm), $rtoi(16384.0 * b / nrm),
                  $rtoi(16384.0 * c / nrm), $rtoi(16384.0 * d / nrm));
        maybe_idle(allow);
    endtask

    task automatic test_directed();
        send_quat(16384, 0, 0, 0);           // identity
        send_quat(0, 16384, 0, 0);           // roll of pi
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);           // yaw of pi
        send_quat(0, 0, 0, 0);               // zero quaternion
        send_quat(11585, 11585, 0, 0);       // quarter turns
        send_quat(11585, 0, 0, 11585);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, 0, 11585, 0);       // just below the clamp
        send_quat(11586, 0, 11586, 0);       // clamp, positive
        send_quat(11586, 0, -11586, 0);      // clamp, negative
        send_quat(8192, 8192, 8192, -8192);  // gimbal lock via z*x term
        send_quat(8192, -8192, -8192, 8192);
        send_quat(-16384, 0, 0, 0);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(32767, 0, -32768, 0);
        send_quat(0, -32768, 0, 0);
        send_quat(1, 0, 0, 0);
        send_quat(0, -1, 0, 1);
        send_quat(-1, -1, -1, -1);
        quat_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_random_unit(int count);
        repeat (count) send_unit(1'b1);
        quat_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_random_raw(int count);
        repeat (count)
        begin
            send_quat($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
            maybe_idle(1'b1);
        end
        quat_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // pitch argument near +/-1: w ~ +/-y, x ~ -/+z
    task automatic test_near_gimbal(int count);
        int a, b, s;
        repeat (count)
        begin
            a = $urandom_range(0, 23170);
            b = $rtoi($sqrt(real'(8192 * 8192 * 8 - a * a)));
            s = $urandom_range(0, 1) ? 1 : -1;
            send_quat(a / 2 + $urandom_range(0, 6) - 3, b / 2 + $urandom_range(0, 6) - 3,
                      s * (a / 2) + $urandom_range(0, 6) - 3,
                      -s * (b / 2) + $urandom_range(0, 6) - 3);
            maybe_idle(1'b1);
        end
        quat_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_drain_pause();
        repeat (20) send_unit(1'b0);
        quat_ch.valid <= 1'b0;
        // hold until every outstanding result is back
        while (angles_pending.size() != 0)
            @(negedge clk);
        repeat (20) send_unit(1'b0);
        quat_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_back_to_back(int count);
        sink_steady = 1'b1;
        repeat (count) send_unit(1'b0);
        quat_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        n_mismatch     = 0;
        n_sent         = 0;
        n_checked      = 0;
        n_clamped      = 0;
        cycle_count    = 0;
        sink_steady    = 1'b0;
        rst_n          = 1'b0;
        quat_ch.valid  = 1'b0;
        quat_ch.quat_w = '0;
        quat_ch.quat_x = '0;
        quat_ch.quat_y = '0;
        quat_ch.quat_z = '0;
        euler_ch.ready = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_unit(600);
        test_random_raw(150);
        test_near_gimbal(120);
        test_drain_pause();
        test_back_to_back(120);

        while (angles_pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("sent %0d quaternions, checked %0d angle sets (%0d with pitch clamped)",
                 n_sent, n_checked, n_clamped);
        $display("covered: axis and extreme inputs, unit and raw random, near gimbal lock");
        if (n_mismatch == 0 && angles_pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
